/* sv/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int PAY_W  = 7;
    localparam int PEND_W = 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_1    = 2'd1;
    localparam logic [PEND_W-1:0] PEND_2    = 2'd2;
    localparam logic [PEND_W-1:0] PEND_3    = 2'd3;

    typedef enum logic [2:0] {
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PAY_W-1:0]  payload;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/utf8_stream_decoder_unit.sv */
// Streaming UTF-8 decoder, one byte per input word.
//
// Input channel: i_valid / o_stall with i_byte_in, one raw byte per word.
// Output channel: o_valid / i_stall with o_code_point, o_seq_length and
// o_error. A word is produced when a sequence of 1 to 4 bytes completes
// (code point and length) or on a bad byte, a stray continuation or a
// missing one (error, code point and length zero; the partial sequence
// and the byte that broke it are dropped). Throughput: one byte per cycle,
// sustained, when the receiver does not stall. Bytes pass front register,
// queue write and output register. A four-entry queue parts the classifier
// from the sequence state, so each side stalls on its own; o_stall rises
// once the queue is full and a byte waits in the front register. While
// i_stall is high the output word holds; the queue keeps filling. Reset
// is synchronous, active low; it empties the queue, clears the sequence
// state and drops any held output word. No clearing pass.
module utf8_stream_decoder_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_byte_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic [u8sd_pkg::LEN_W-1:0] o_seq_length,
    output logic                       o_error
);
    import u8sd_pkg::*;

    logic      push;
    logic      pop;
    t_item     front_item;
    t_item     head;
    t_q_status q_stat;

    u8sd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_byte_in (i_byte_in),
        .i_q_full  (q_stat.full),
        .o_push    (push),
        .o_item    (front_item)
    );

    u8sd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_stat)
    );

    u8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_empty    (q_stat.empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length),
        .o_error      (o_error)
    );

`ifndef SYNTHESIS
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_code_point == '0 && o_seq_length == LEN_NONE))
        else $error("error word carries data");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error) |-> (o_seq_length != LEN_NONE))
        else $error("good word with zero length");
`endif

endmodule

/* sv/u8sd_front.sv */
// Front end: accept bytes, classify them and hand them to the queue.
module u8sd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_byte_in,
    input  logic           i_q_full,
    output logic           o_push,
    output u8sd_pkg::t_item o_item
);
    import u8sd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  load;

    always_comb begin
        n_item.kind    = K_BAD;
        n_item.payload = '0;
        case (i_byte_in) inside
            [8'h00:8'h7F]: begin
                n_item.kind    = K_ASCII;
                n_item.payload = i_byte_in[6:0];
            end
            [8'h80:8'hBF]: begin
                n_item.kind    = K_CONT;
                n_item.payload = {1'b0, i_byte_in[5:0]};
            end
            [8'hC0:8'hDF]: begin
                n_item.kind    = K_LEAD2;
                n_item.payload = {2'b0, i_byte_in[4:0]};
            end
            [8'hE0:8'hEF]: begin
                n_item.kind    = K_LEAD3;
                n_item.payload = {3'b0, i_byte_in[3:0]};
            end
            [8'hF0:8'hF7]: begin
                n_item.kind    = K_LEAD4;
                n_item.payload = {4'b0, i_byte_in[2:0]};
            end
            default: begin
                n_item.kind    = K_BAD;
                n_item.payload = '0;
            end
        endcase
    end

    assign o_push  = r_valid && !i_q_full;
    assign load    = !r_valid || !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/u8sd_queue.sv */
// Short queue of classified words between front end and back end.
module u8sd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8sd_pkg::t_item     i_item,
    input  logic                i_pop,
    output u8sd_pkg::t_item     o_head,
    output u8sd_pkg::t_q_status o_status
);
    import u8sd_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/u8sd_back.sv */
// Back end: sequence state, code point assembly and output register.
module u8sd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  u8sd_pkg::t_item               i_head,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8sd_pkg::CP_W-1:0]     o_code_point,
    output logic [u8sd_pkg::LEN_W-1:0]    o_seq_length,
    output logic                          o_error
);
    import u8sd_pkg::*;

    logic [PEND_W-1:0] r_pend,    n_pend;
    logic [LEN_W-1:0]  r_total,   n_total;
    logic [CP_W-1:0]   r_partial, n_partial;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_cp;
    logic [LEN_W-1:0]  r_len;
    logic              r_err;
    logic              emit;
    logic [CP_W-1:0]   e_cp;
    logic [LEN_W-1:0]  e_len;
    logic              e_err;
    logic [CP_W-1:0]   shifted;

    assign o_pop   = !i_q_empty && (!r_out_valid || !i_stall);
    assign shifted = {r_partial[CP_W-7:0], i_head.payload[5:0]};

    always_comb begin
        n_pend    = r_pend;
        n_total   = r_total;
        n_partial = r_partial;
        emit      = 1'b0;
        e_cp      = '0;
        e_len     = LEN_NONE;
        e_err     = 1'b0;
        if (r_pend != PEND_NONE) begin
            if (i_head.kind != K_CONT) begin
                n_pend    = PEND_NONE;
                n_total   = LEN_NONE;
                n_partial = '0;
                emit      = 1'b1;
                e_err     = 1'b1;
            end else if (r_pend == PEND_1) begin
                n_pend    = PEND_NONE;
                n_total   = LEN_NONE;
                n_partial = '0;
                emit      = 1'b1;
                e_cp      = shifted;
                e_len     = r_total;
            end else begin
                n_pend    = r_pend - PEND_1;
                n_partial = shifted;
            end
        end else begin
            case (i_head.kind)
                K_ASCII: begin
                    emit  = 1'b1;
                    e_cp  = CP_W'(i_head.payload);
                    e_len = LEN_1;
                end
                K_LEAD2: begin
                    n_pend    = PEND_1;
                    n_total   = LEN_2;
                    n_partial = CP_W'(i_head.payload);
                end
                K_LEAD3: begin
                    n_pend    = PEND_2;
                    n_total   = LEN_3;
                    n_partial = CP_W'(i_head.payload);
                end
                K_LEAD4: begin
                    n_pend    = PEND_3;
                    n_total   = LEN_4;
                    n_partial = CP_W'(i_head.payload);
                end
                default: begin
                    emit  = 1'b1;
                    e_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= PEND_NONE;
            r_total     <= LEN_NONE;
            r_partial   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pend    <= n_pend;
                r_total   <= n_total;
                r_partial <= n_partial;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_cp  <= e_cp;
            r_len <= e_len;
            r_err <= e_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_cp;
    assign o_seq_length = r_len;
    assign o_error      = r_err;

endmodule
